// ===== hw/rtl/tscw_pkg.sv =====
// shared types and constants of the text screen character writer
package tscw_pkg;

  localparam int unsigned SCREEN_BYTES_DEF = 1024;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_PAGE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_PAGE   = 1'd1;

  localparam logic [7:0]  START_PAGE_RST = 8'd248;
  localparam logic [7:0]  END_PAGE_RST   = 8'd252;
  localparam logic [15:0] CURSOR_RST     = 16'hf800;

  localparam logic [7:0] CELL_BLANK  = 8'h7f;
  localparam logic [7:0] CELL_CURSOR = 8'hff;
  localparam logic [7:0] ATTR_BIT    = 8'h80;

  localparam logic [7:0] CHAR_CANCEL = 8'h18;
  localparam logic [7:0] CHAR_DEL    = 8'h7f;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_FF     = 8'h0c;
  localparam logic [7:0] CHAR_VT     = 8'h0b;
  localparam logic [7:0] CHAR_TAB    = 8'h09;

  localparam logic [15:0] LINE_MASK  = 16'hffc0;
  localparam logic [15:0] TAB_MASK   = 16'hfff8;
  localparam logic [15:0] COL_MASK   = 16'h003f;
  localparam logic [15:0] LINE_BYTES = 16'd64;
  localparam logic [15:0] TAB_STEP   = 16'd8;
  // 63 blanked columns, counted 0..62
  localparam logic [5:0]  LINE_LAST  = 6'd62;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [9:0] cell_offset;
  } tscw_in_t;

  typedef struct packed {
    logic [15:0] cursor_address;
    logic [7:0]  cell_data;
    logic        scrolled;
  } tscw_out_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_READ,
    DP_PUT,
    DP_FF,
    DP_COPY,
    DP_COPY_END,
    DP_LINE,
    DP_MARK
  } tscw_dp_op_e;

  typedef struct packed {
    logic        take;
    tscw_dp_op_e op;
    logic        out_load;
  } tscw_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_cancel;
    logic is_ff;
    logic scroll_hit;
    logic clr_last;
    logic ff_last;
    logic copy_last;
    logic line_last;
    logic out_free;
  } tscw_status_t;

endpackage

// ===== hw/rtl/tscw_dp.sv =====
// datapath: screen store, cursor, sweep counter, config and result registers
module tscw_dp import tscw_pkg::*; #(
  parameter int unsigned SCREEN_BYTES = SCREEN_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tscw_in_t               in_data_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output tscw_out_t              out_data_o,
  input  logic                   cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  input  tscw_cmd_t              cmd_i,
  output tscw_status_t           status_o
);

  localparam int unsigned IW = $clog2(SCREEN_BYTES);
  localparam logic [16:0] SB17 = 17'(SCREEN_BYTES);

  logic [7:0]      start_q, end_q;
  logic [15:0]     pos_q, pos_d;
  logic [IW-1:0]   cnt_q, cnt_d;
  logic            op_q;
  logic [7:0]      ch_q;
  logic [9:0]      off_q;
  logic            scrolled_q;
  logic            cp_pend_q;
  logic [IW-1:0]   cp_idx_q;
  logic            cp_ok_q;
  logic            rd_ok_q;
  logic            out_valid_q;
  tscw_out_t       out_q;
  logic [7:0]      mem_q [SCREEN_BYTES];
  logic [7:0]      rdata_q;

  logic [15:0] home;
  logic [7:0]  pages_m;
  logic [16:0] span, ff_lim, copy_lim, cnt_nx;
  logic [15:0] copy_cnt;
  logic [15:0] line_addr, waddr16, widx16;
  logic        wok;
  logic [16:0] off17, src17;
  logic        rok, sok;
  logic        printable;
  logic [7:0]  put_data;
  logic [15:0] put_pos;
  logic        we, rd_en;
  logic [IW-1:0] waddr, raddr;
  logic [7:0]  wdata;
  logic        out_free;

  assign home     = {start_q, 8'h00};
  assign pages_m  = end_q - start_q;
  // zero page difference means a full 256 pages
  assign span     = (pages_m == 8'd0) ? 17'h10000 : {1'b0, pages_m, 8'h00};
  assign ff_lim   = (span < SB17) ? span : SB17;
  assign copy_cnt = {pages_m, 8'h00} - LINE_BYTES;
  assign copy_lim = ({1'b0, copy_cnt} < SB17) ? {1'b0, copy_cnt} : SB17;
  assign cnt_nx   = 17'(cnt_q) + 17'd1;

  assign line_addr = (pos_q | COL_MASK) - {10'd0, cnt_q[5:0]};
  assign waddr16   = (cmd_i.op == DP_LINE) ? line_addr : pos_q;
  assign widx16    = waddr16 - home;
  assign wok       = {1'b0, widx16} < SB17;

  assign off17 = {7'd0, off_q};
  assign rok   = off17 < SB17;
  assign src17 = 17'(cnt_q) + 17'(LINE_BYTES);
  assign sok   = src17 < SB17;

  assign printable = (ch_q >= CHAR_SPACE) && (ch_q != CHAR_DEL);
  assign put_data  = printable ? (ch_q | ATTR_BIT) : CELL_BLANK;

  always_comb begin
    if (ch_q == CHAR_DEL) begin
      put_pos = pos_q - 16'd1;
    end else if (printable) begin
      put_pos = pos_q + 16'd1;
    end else if (ch_q == CHAR_CR) begin
      put_pos = (pos_q & LINE_MASK) + LINE_BYTES;
    end else if ((ch_q == CHAR_FF) || (ch_q == CHAR_VT)) begin
      put_pos = home;
    end else if (ch_q == CHAR_TAB) begin
      put_pos = (pos_q & TAB_MASK) + TAB_STEP;
    end else begin
      put_pos = pos_q;
    end
  end

  // single write port; a pending copy write owns it in the cycle after a copy read
  always_comb begin
    we    = 1'b0;
    waddr = widx16[IW-1:0];
    wdata = CELL_BLANK;
    if (cp_pend_q) begin
      we    = 1'b1;
      waddr = cp_idx_q;
      wdata = cp_ok_q ? rdata_q : CELL_BLANK;
    end else begin
      case (cmd_i.op) inside
        DP_CLEAR, DP_FF: begin
          we    = 1'b1;
          waddr = cnt_q;
        end
        DP_PUT: begin
          we    = wok;
          wdata = put_data;
        end
        DP_LINE: begin
          we = wok;
        end
        DP_MARK: begin
          we    = wok;
          wdata = CELL_CURSOR;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_en = 1'b0;
    raddr = src17[IW-1:0];
    case (cmd_i.op)
      DP_READ: begin
        rd_en = rok;
        raddr = off17[IW-1:0];
      end
      DP_COPY: begin
        rd_en = sok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    pos_d = pos_q;
    case (cmd_i.op)
      DP_PUT:      pos_d = put_pos;
      DP_COPY_END: pos_d = {end_q, 8'h00} - 16'd1;
      DP_LINE:     if (status_o.line_last) pos_d = pos_q & LINE_MASK;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.take) begin
      cnt_d = '0;
    end else begin
      case (cmd_i.op)
        DP_CLEAR: cnt_d = status_o.clr_last  ? '0 : cnt_q + 1'b1;
        DP_FF:    cnt_d = status_o.ff_last   ? '0 : cnt_q + 1'b1;
        DP_COPY:  cnt_d = status_o.copy_last ? '0 : cnt_q + 1'b1;
        DP_LINE:  cnt_d = status_o.line_last ? '0 : cnt_q + 1'b1;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= START_PAGE_RST;
      end_q       <= END_PAGE_RST;
      pos_q       <= CURSOR_RST;
      cnt_q       <= '0;
      scrolled_q  <= 1'b0;
      cp_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_START_PAGE) begin
          start_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_END_PAGE) begin
          end_q <= cfg_data_i;
        end
      end
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      cp_pend_q <= (cmd_i.op == DP_COPY);
      if (cmd_i.take) begin
        scrolled_q <= 1'b0;
      end else if (cmd_i.op == DP_COPY_END) begin
        scrolled_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= in_data_i.opcode;
      ch_q  <= in_data_i.char_code;
      off_q <= in_data_i.cell_offset;
    end
    if (cmd_i.op == DP_COPY) begin
      cp_idx_q <= cnt_q;
      cp_ok_q  <= sok;
    end
    if (cmd_i.op == DP_READ) begin
      rd_ok_q <= rok;
    end
    if (cmd_i.out_load) begin
      out_q.cursor_address <= pos_q;
      out_q.cell_data      <= (op_q && rd_ok_q) ? rdata_q : 8'h00;
      out_q.scrolled       <= scrolled_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.is_read    = op_q;
  assign status_o.is_cancel  = (ch_q == CHAR_CANCEL);
  assign status_o.is_ff      = (ch_q == CHAR_FF);
  assign status_o.scroll_hit = (pos_q[15:8] == end_q);
  assign status_o.clr_last   = (cnt_nx == SB17);
  assign status_o.ff_last    = (cnt_nx == ff_lim);
  assign status_o.copy_last  = (cnt_nx == copy_lim);
  assign status_o.line_last  = (cnt_q[5:0] == LINE_LAST);
  assign status_o.out_free   = out_free;

endmodule

// ===== hw/rtl/tscw_ctrl.sv =====
// controller: sequences clear pass, item execution, sweeps and result hand-off
module tscw_ctrl import tscw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  tscw_status_t status_i,
  output tscw_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_EXEC     = 10'b0000000100,
    S_RESP     = 10'b0000001000,
    S_FF       = 10'b0000010000,
    S_CHECK    = 10'b0000100000,
    S_COPY     = 10'b0001000000,
    S_COPY_END = 10'b0010000000,
    S_LINE     = 10'b0100000000,
    S_MARK     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_stall_o     = 1'b1;
    cmd_o.take     = 1'b0;
    cmd_o.op       = DP_NOP;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.is_read) begin
          cmd_o.op = DP_READ;
          state_d  = S_RESP;
        end else if (status_i.is_cancel) begin
          state_d = S_LINE;
        end else begin
          cmd_o.op = DP_PUT;
          state_d  = status_i.is_ff ? S_FF : S_CHECK;
        end
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FF: begin
        cmd_o.op = DP_FF;
        if (status_i.ff_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = status_i.scroll_hit ? S_COPY : S_MARK;
      end
      S_COPY: begin
        cmd_o.op = DP_COPY;
        if (status_i.copy_last) state_d = S_COPY_END;
      end
      S_COPY_END: begin
        // last copy write lands here, cursor moves to the bottom line
        cmd_o.op = DP_COPY_END;
        state_d  = S_LINE;
      end
      S_LINE: begin
        cmd_o.op = DP_LINE;
        if (status_i.line_last) state_d = S_MARK;
      end
      S_MARK: begin
        cmd_o.op = DP_MARK;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/text_screen_character_writer_core.sv =====
// text screen character writer: top level joining controller and datapath
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one item per
//   transaction: opcode 0 puts char_code at the cursor, opcode 1 reads the
//   cell at cell_offset. Every item gives exactly one result on the output
//   channel (out_valid_o / out_stall_i / out_data_o): cursor after the item,
//   the cell read (0 for puts) and a scroll flag.
//   Config port (cfg_valid_i / cfg_ready_o) writes start page (index 0) and
//   end page (index 1); ready is always high, write only while idle.
// Flow: one item at a time through the single-port screen store.
//   form feed also blanks min(SCREEN_BYTES, page span) cells of the store.
//   a scroll copies min(SCREEN_BYTES, page span - 64) cells up one line and
//   blanks 63 cells of the bottom line; ^X blanks 63 cells of the line.
// After reset the store is swept to blank, SCREEN_BYTES cells, with
//   in_stall_o high. The result sits in an output register; while the
//   receiver stalls the next item is still taken and held at its last step.
module text_screen_character_writer_core import tscw_pkg::*; #(
  parameter int unsigned SCREEN_BYTES = SCREEN_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  tscw_in_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tscw_out_t              out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [7:0]             cfg_data_i
);

  tscw_cmd_t    cmd;
  tscw_status_t status;

  assign cfg_ready_o = 1'b1;

  tscw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tscw_dp #(
    .SCREEN_BYTES (SCREEN_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== dv/tscw_tb_pkg.sv =====
// operation codes shared by the testbench modules of the text screen writer
package tscw_tb_pkg;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

// ===== dv/tscw_checker.sv =====
// checker for the text screen writer: predicts each transaction and compares the results
module tscw_checker import tscw_pkg::*; import tscw_tb_pkg::*; #(
  parameter int unsigned SCREEN_BYTES = SCREEN_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  tscw_in_t               in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  tscw_out_t              out_data_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [7:0]             cfg_data_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHOWN_FAILS = 10;
  localparam int unsigned IDX_W = $clog2(SCREEN_BYTES);

  logic [7:0]  start_pg;
  logic [7:0]  end_pg;
  logic [15:0] cursor;
  logic [7:0]  cells [SCREEN_BYTES];
  tscw_out_t   screen_results_q [$];

  // cells outside the store are not kept
  function automatic void store_cell(input logic [15:0] addr, input logic [7:0] val);
    logic [15:0] idx;
    idx = addr - {start_pg, 8'h00};
    if (idx < SCREEN_BYTES) cells[idx[IDX_W-1:0]] = val;
  endfunction

  // blanks columns 63..1 of the line, returns column 0
  function automatic logic [15:0] blank_row(input logic [15:0] addr);
    logic [15:0] p;
    p = addr | COL_MASK;
    for (int n = 0; n < 63; n++) begin
      store_cell(p, CELL_BLANK);
      p = p - 16'd1;
    end
    return p;
  endfunction

  function automatic tscw_out_t screen_step(input tscw_in_t it);
    tscw_out_t   r;
    logic [15:0] pos;
    logic [15:0] home;
    logic [7:0]  span8;
    logic [15:0] count;
    int unsigned pages;
    r = '0;
    pos = cursor;
    home = {start_pg, 8'h00};
    span8 = end_pg - start_pg;
    pages = (span8 == 8'd0) ? 256 : span8;

    if (it.opcode == OP_READ) begin
      r.cursor_address = cursor;
      r.cell_data = (it.cell_offset < SCREEN_BYTES) ? cells[IDX_W'(it.cell_offset)] : 8'h00;
      return r;
    end

    if (it.char_code == CHAR_CANCEL) begin
      pos = blank_row(pos);
      store_cell(pos, CELL_CURSOR);
      cursor = pos;
      r.cursor_address = pos;
      return r;
    end

    store_cell(pos, CELL_BLANK);
    if (it.char_code == CHAR_DEL) begin
      pos = pos - 16'd1;
    end else if (it.char_code >= CHAR_SPACE) begin
      store_cell(pos, it.char_code | ATTR_BIT);
      pos = pos + 16'd1;
    end else if (it.char_code == CHAR_CR) begin
      pos = (pos & LINE_MASK) + LINE_BYTES;
    end else if (it.char_code == CHAR_FF) begin
      for (int unsigned i = 0; i < SCREEN_BYTES; i++)
        if (i < pages * 256) cells[IDX_W'(i)] = CELL_BLANK;
      pos = home;
    end else if (it.char_code == CHAR_VT) begin
      pos = home;
    end else if (it.char_code == CHAR_TAB) begin
      pos = (pos & TAB_MASK) + TAB_STEP;
    end

    if (pos[15:8] == end_pg) begin
      // a full 256-page span wraps to a count of 65472
      count = {span8, 8'h00} - LINE_BYTES;
      for (int unsigned i = 0; i < count && i < SCREEN_BYTES; i++)
        cells[IDX_W'(i)] = (i + LINE_BYTES < SCREEN_BYTES) ?
                           cells[IDX_W'(i + LINE_BYTES)] : CELL_BLANK;
      pos = {end_pg, 8'h00} - 16'd1;
      pos = blank_row(pos);
      r.scrolled = 1'b1;
    end

    store_cell(pos, CELL_CURSOR);
    cursor = pos;
    r.cursor_address = pos;
    return r;
  endfunction

  task automatic note_fail(input string msg);
    fail_count_o++;
    if (fail_count_o <= SHOWN_FAILS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tscw_out_t want;
    if (!rst_ni) begin
      start_pg = START_PAGE_RST;
      end_pg = END_PAGE_RST;
      cursor = CURSOR_RST;
      foreach (cells[i]) cells[i] = CELL_BLANK;
      screen_results_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (screen_results_q.size() == 0) begin
          note_fail($sformatf("result with none expected: cursor %h cell %h scrolled %b",
                              out_data_i.cursor_address, out_data_i.cell_data,
                              out_data_i.scrolled));
        end else begin
          want = screen_results_q.pop_front();
          if (out_data_i.cursor_address !== want.cursor_address)
            note_fail($sformatf("cursor_address expected %h got %h",
                                want.cursor_address, out_data_i.cursor_address));
          if (out_data_i.cell_data !== want.cell_data)
            note_fail($sformatf("cell_data expected %h got %h",
                                want.cell_data, out_data_i.cell_data));
          if (out_data_i.scrolled !== want.scrolled)
            note_fail($sformatf("scrolled expected %b got %b",
                                want.scrolled, out_data_i.scrolled));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_START_PAGE: start_pg = cfg_data_i;
          CFG_END_PAGE:   end_pg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) screen_results_q.push_back(screen_step(in_data_i));
      pending_o = screen_results_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top of the text screen writer: stimulus, flow control and verdict
module tb_top import tscw_pkg::*; import tscw_tb_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned PHASE_ITEMS = 240;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned TAIL        = 20;
  localparam int unsigned LONG_HOLD   = 300;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  tscw_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  tscw_out_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;
  int unsigned            fail_count;
  int unsigned            pending;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_screen_character_writer_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tscw_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: decides at the rising edge, drives at the falling edge
  initial begin
    logic stall_next;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        stall_next = 1'b1;
        hold_cycles--;
      end else begin
        stall_next = ($urandom_range(99) < stall_pct);
      end
      @(negedge clk);
      out_stall <= stall_next;
    end
  end

  // no transaction of any kind for too long means the block hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL text_screen_character_writer_core");
      $finish;
    end
  end

  function automatic tscw_in_t mk_item(input logic op, input logic [7:0] ch,
                                       input logic [9:0] off);
    tscw_in_t it;
    it.opcode = op;
    it.char_code = ch;
    it.cell_offset = off;
    return it;
  endfunction

  // mostly text with line control mixed in, a few reads and slow screen clears
  function automatic tscw_in_t rand_item();
    tscw_in_t    it;
    int unsigned roll;
    it.opcode = OP_PUT;
    it.char_code = 8'($urandom_range(8'hff, 8'h20));
    it.cell_offset = 10'($urandom_range(SCREEN_BYTES_DEF - 1));
    roll = $urandom_range(99);
    if (roll < 12) begin
      it.opcode = OP_READ;
      it.char_code = 8'($urandom_range(8'hff));
    end else if (roll < 20) it.char_code = CHAR_CR;
    else if (roll < 25) it.char_code = CHAR_TAB;
    else if (roll < 29) it.char_code = CHAR_DEL;
    else if (roll < 32) it.char_code = CHAR_VT;
    else if (roll == 32) it.char_code = CHAR_FF;
    else if (roll < 36) it.char_code = CHAR_CANCEL;
    else if (roll < 40) it.char_code = 8'($urandom_range(8'h1f));
    return it;
  endfunction

  // entered and left at a falling edge; valid stays high for back-to-back items
  task automatic send_item(input tscw_in_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_screen(input logic [7:0] first_page, input logic [7:0] last_page);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_START_PAGE;
    cfg_data <= first_page;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= CFG_END_PAGE;
    cfg_data <= last_page;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    tscw_in_t   plan [$];
    logic [7:0] start_tab [NUM_PHASES];
    logic [7:0] end_tab [NUM_PHASES];
    start_tab = '{8'd248, 8'd0, 8'd255, 8'd0, 8'd255, 8'd16, 8'd252, 8'd248};
    end_tab   = '{8'd252, 8'd4, 8'd3,   8'd0, 8'd255, 8'd17, 8'd248, 8'd252};

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset screen: blank reads, text extremes, several control bytes, leaving the store
    plan = '{mk_item(OP_READ, 8'h00, 10'd0),
             mk_item(OP_READ, 8'hff, 10'd1023),
             mk_item(OP_PUT, 8'h20, 10'd0),
             mk_item(OP_PUT, 8'h7e, 10'd0),
             mk_item(OP_PUT, 8'h80, 10'd0),
             mk_item(OP_PUT, 8'hff, 10'd0),
             mk_item(OP_READ, 8'h00, 10'd1),
             mk_item(OP_PUT, 8'h00, 10'd0),
             mk_item(OP_PUT, 8'h1f, 10'd0),
             mk_item(OP_PUT, CHAR_TAB, 10'd0),
             mk_item(OP_PUT, CHAR_DEL, 10'd0),
             mk_item(OP_PUT, CHAR_CANCEL, 10'd0),
             mk_item(OP_PUT, CHAR_DEL, 10'd0),
             mk_item(OP_PUT, 8'h41, 10'd0),
             mk_item(OP_PUT, CHAR_FF, 10'd0),
             mk_item(OP_READ, 8'h00, 10'd0)};
    foreach (plan[i]) send_item(plan[i]);
    drain();
    repeat (SETTLE) @(negedge clk);

    // one-page screen moved under the old store, four line feeds reach the end page
    set_screen(8'd251, 8'd252);
    plan = '{mk_item(OP_PUT, CHAR_VT, 10'd0),
             mk_item(OP_PUT, CHAR_CR, 10'd0),
             mk_item(OP_PUT, CHAR_CR, 10'd0),
             mk_item(OP_PUT, CHAR_CR, 10'd0),
             mk_item(OP_PUT, CHAR_CR, 10'd0),
             mk_item(OP_READ, 8'h00, 10'd0)};
    foreach (plan[i]) send_item(plan[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      repeat (SETTLE) @(negedge clk);
      set_screen(start_tab[ph], end_tab[ph]);
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 70; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 70; end
        default: begin send_gap_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // receiver holds off long enough to back the block up
        if (ph == 0 && n == 100) hold_cycles = LONG_HOLD;
        if (ph == 4 && n == 120) drain();
        // second half of the phase: items sent back to back with no receiver stalls
        if (n == PHASE_ITEMS / 2) begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        send_item(rand_item());
      end
    end

    drain();
    repeat (TAIL) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASS text_screen_character_writer_core");
    else
      $display("FAIL text_screen_character_writer_core");
    $finish;
  end

endmodule
